[src/wlcg_pkg.sv]
// Package for the line collapse generator: payload structs and shared constants.
// No dependencies.
`timescale 1ns / 1ps
package wlcg_pkg;
   localparam logic ACT_WRITE = 1'b0;
   localparam logic ACT_GEN   = 1'b1;
   localparam int   CSR_ACTIVE = 0;
   localparam int   CSR_DIR    = 1;
   localparam logic [9:0] TALLY_MAX = 10'h3FF;

   typedef struct packed {
      logic        action;
      logic [5:0]  entry_index;
      logic [63:0] right_mask;
      logic [63:0] down_mask;
      logic [15:0] weight;
      logic        is_floor;
      logic        first_cell;
      logic        neighbour_valid;
      logic [5:0]  neighbour_pattern;
      logic [30:0] random_value;
   } req_type;

   typedef struct packed {
      logic [5:0] chosen_pattern;
      logic       contradiction;
      logic [9:0] line_contradictions;
   } rsp_type;
endpackage

[src/wlcg_ram.sv]
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module wlcg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

[src/wlcg_fifo.sv]
// Short request queue between the front and back parts.
// Depends on wlcg_pkg.
`timescale 1ns / 1ps
module wlcg_fifo import wlcg_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  req_type push_data,
   output logic    full,
   input  logic    pop,
   output logic    not_empty,
   output req_type pop_data
);
   req_type     q_ff [2];
   logic        wp_ff, rp_ff;
   logic [1:0]  cnt_ff;
   assign full      = cnt_ff == 2'd2;
   assign not_empty = cnt_ff != 2'd0;
   assign pop_data  = q_ff[rp_ff];
   always_ff @(posedge clock) begin
      if (push) q_ff[wp_ff] <= push_data;
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= 2'd0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (pop)  rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end
endmodule

[src/wlcg_front.sv]
// Front part: takes requests, filters out table writes that hit no entry, queues the rest.
// Depends on wlcg_pkg and wlcg_fifo.
`timescale 1ns / 1ps
module wlcg_front import wlcg_pkg::*; #(
   parameter int MAX_PATTERNS = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   input  logic    pop,
   output logic    not_empty,
   output req_type pop_data
);
   logic full, in_range, push;
   assign in_range  = {1'b0, req_data.entry_index} < 7'(MAX_PATTERNS);
   assign req_stall = full;
   // writes beyond the table are dropped here
   assign push = req_valid && !full && (req_data.action == ACT_GEN || in_range);
   wlcg_fifo u_fifo (
      .clock, .reset, .push, .push_data(req_data), .full,
      .pop, .not_empty, .pop_data
   );
endmodule

[src/wlcg_back.sv]
// Back part: owns the pattern table and runs the weighted pick one pattern per cycle.
// Depends on wlcg_pkg and wlcg_ram.
`timescale 1ns / 1ps
module wlcg_back import wlcg_pkg::*; #(
   parameter int MAX_PATTERNS = 64,
   parameter int WEIGHT_BITS  = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic [6:0] active_patterns,
   input  logic       line_direction,
   input  logic       q_valid,
   input  req_type    q_data,
   output logic       q_pop,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_data
);
   localparam int AW = $clog2(MAX_PATTERNS);
   localparam int TW = WEIGHT_BITS + AW;   // total weight width
   localparam int CW = AW + 1;             // count width

   localparam logic [3:0] S_IDLE = 4'd0, S_NRD = 4'd1, S_NMSK = 4'd2, S_PRD = 4'd3,
                          S_PMSK = 4'd4, S_SUM = 4'd5, S_MOD = 4'd6, S_PICK = 4'd7,
                          S_OUT = 4'd8;

   logic [3:0]  st_ff, st_in;
   req_type     cur_ff;
   logic [MAX_PATTERNS-1:0] cand_ff;
   logic [CW-1:0] n_ff, p_ff;
   logic [TW-1:0] tot_ff, acc_ff;
   logic [TW+31:0] rem_ff;
   logic [5:0]  bit_ff;
   logic [AW-1:0] chosen_ff, fb_ff;
   logic        found_ff, fbf_ff;
   logic        prev_v_ff;
   logic [AW-1:0] prev_ff;
   logic [9:0]  tally_ff;
   logic        ov_ff;
   rsp_type     res_ff;
   rsp_type     out_ff;

   logic wr;
   logic [AW-1:0] rd_addr;
   logic [63:0] rmask, dmask;
   logic [WEIGHT_BITS-1:0] wgt;
   logic flr;

   assign wr = st_ff == S_IDLE && q_valid && q_data.action == ACT_WRITE;

   wlcg_ram #(.WIDTH(64), .DEPTH(MAX_PATTERNS)) u_right (
      .clock, .wr_en(wr), .wr_addr(q_data.entry_index[AW-1:0]),
      .wr_data(q_data.right_mask), .rd_addr, .rd_data(rmask));
   wlcg_ram #(.WIDTH(64), .DEPTH(MAX_PATTERNS)) u_down (
      .clock, .wr_en(wr), .wr_addr(q_data.entry_index[AW-1:0]),
      .wr_data(q_data.down_mask), .rd_addr, .rd_data(dmask));
   wlcg_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(MAX_PATTERNS)) u_wgt (
      .clock, .wr_en(wr), .wr_addr(q_data.entry_index[AW-1:0]),
      .wr_data(WEIGHT_BITS'(q_data.weight)), .rd_addr, .rd_data(wgt));
   wlcg_ram #(.WIDTH(1), .DEPTH(MAX_PATTERNS)) u_flr (
      .clock, .wr_en(wr), .wr_addr(q_data.entry_index[AW-1:0]),
      .wr_data(q_data.is_floor), .rd_addr, .rd_data(flr));

   logic [MAX_PATTERNS-1:0] nmask, pmask, valid_mask;
   logic nb_in_range;
   assign nmask = line_direction ? dmask[MAX_PATTERNS-1:0] : rmask[MAX_PATTERNS-1:0];
   assign pmask = line_direction ? rmask[MAX_PATTERNS-1:0] : dmask[MAX_PATTERNS-1:0];
   assign nb_in_range = {1'b0, cur_ff.neighbour_pattern} < 7'(MAX_PATTERNS);
   always_comb begin
      for (int i = 0; i < MAX_PATTERNS; i++) valid_mask[i] = CW'(i) < n_ff;
   end

   logic [CW-1:0] n_clip;
   assign n_clip = active_patterns > 7'(MAX_PATTERNS) ? CW'(MAX_PATTERNS) : active_patterns[CW-1:0];

   // restoring-remainder step: one bit of the 31-bit random word per cycle
   logic [TW+31:0] shifted;
   logic [TW:0]    trial;
   logic [TW-1:0]  rem_q;
   assign shifted = {rem_ff[TW+30:0], 1'b0};
   assign trial   = shifted[TW+31:31] - {1'b0, tot_ff};
   assign rem_q   = rem_ff[TW+30:31];

   logic [TW-1:0] acc_next;
   logic [CW-1:0] p_inc;
   logic          cur_bit, last_p;
   assign cur_bit  = cand_ff[p_ff[AW-1:0]];
   assign acc_next = acc_ff + TW'(wgt);
   assign p_inc    = p_ff + CW'(1);
   assign last_p   = p_inc >= n_ff;

   // RAM read data is registered: during the table passes the address is the
   // next p value, so the data present in a cycle belongs to p_ff.
   always_comb begin
      case (st_ff)
         S_IDLE:  rd_addr = q_data.neighbour_pattern[AW-1:0];
         S_NRD:   rd_addr = cur_ff.neighbour_pattern[AW-1:0];
         S_PRD:   rd_addr = prev_ff;
         S_PMSK:  rd_addr = '0;
         S_SUM:   rd_addr = last_p ? '0 : p_inc[AW-1:0];
         S_PICK:  rd_addr = p_inc[AW-1:0];
         default: rd_addr = p_ff[AW-1:0];
      endcase
   end

   logic [9:0] tally_base;
   assign tally_base = cur_ff.first_cell ? 10'd0 : tally_ff;

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         S_IDLE: if (q_valid && q_data.action == ACT_GEN) st_in = S_NRD;
         S_NRD:  st_in = S_NMSK;
         S_NMSK: st_in = S_PRD;
         S_PRD:  st_in = S_PMSK;
         S_PMSK: st_in = n_ff == '0 ? S_OUT : S_SUM;
         S_SUM:  if (last_p) st_in = tot_ff + (cur_bit ? TW'(wgt) : '0) == '0 ? S_OUT : S_MOD;
         S_MOD:  if (bit_ff == 6'd30) st_in = S_PICK;
         S_PICK: if (last_p || found_ff) st_in = S_OUT;
         S_OUT:  if (!ov_ff || !rsp_stall) st_in = S_IDLE;
         default: st_in = S_IDLE;
      endcase
   end

   assign q_pop = st_ff == S_IDLE && q_valid;

   always_ff @(posedge clock) begin
      unique case (st_ff)
         S_IDLE: begin
            cur_ff <= q_data;
            n_ff   <= n_clip;
         end
         S_NRD: ;
         S_NMSK: begin
            cand_ff <= valid_mask &
                       (cur_ff.neighbour_valid ? (nb_in_range ? nmask : '0) : '1);
         end
         S_PRD: ;
         S_PMSK: begin
            if (prev_v_ff && !cur_ff.first_cell) cand_ff <= cand_ff & pmask;
            p_ff <= '0; tot_ff <= '0; found_ff <= 1'b0; fbf_ff <= 1'b0; fb_ff <= '0;
         end
         S_SUM: begin
            if (cur_bit) tot_ff <= tot_ff + TW'(wgt);
            if (flr && !fbf_ff) begin fbf_ff <= 1'b1; fb_ff <= p_ff[AW-1:0]; end
            p_ff <= last_p ? '0 : p_inc;
            rem_ff <= {(TW+1)'(0), cur_ff.random_value};
            bit_ff <= '0; acc_ff <= '0;
         end
         S_MOD: begin
            rem_ff <= trial[TW] ? shifted
                                : {trial[TW-1:0], shifted[30:0], 1'b0} >> 1;
            bit_ff <= bit_ff + 6'd1;
         end
         S_PICK: begin
            if (cur_bit && !found_ff) begin
               acc_ff <= acc_next;
               if (acc_next > rem_q) begin
                  found_ff <= 1'b1; chosen_ff <= p_ff[AW-1:0];
               end
            end
            p_ff <= p_inc;
         end
         S_OUT: ;
         default: ;
      endcase
   end

   logic is_found_now;
   logic [AW-1:0] pick_now;
   logic [AW-1:0] fb_now;
   assign is_found_now = found_ff || (cur_bit && acc_next > rem_q);
   assign pick_now = found_ff ? chosen_ff : p_ff[AW-1:0];

   // fallback: first floor pattern seen so far, including the one in this cycle
   always_comb begin
      fb_now = '0;
      if (st_ff == S_SUM && !fbf_ff && flr) fb_now = p_ff[AW-1:0];
      else if (st_ff != S_PMSK && fbf_ff)  fb_now = fb_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff     <= S_IDLE;
         ov_ff     <= 1'b0;
         prev_v_ff <= 1'b0;
         tally_ff  <= '0;
      end else begin
         st_ff <= st_in;
         // the finished cell moves to the output only once the slot is free
         if (st_ff == S_OUT && (!ov_ff || !rsp_stall)) begin
            ov_ff  <= 1'b1;
            out_ff <= res_ff;
         end else if (ov_ff && !rsp_stall) ov_ff <= 1'b0;
         if (st_in == S_OUT && st_ff != S_OUT) begin
            prev_v_ff <= 1'b1;
            res_ff.contradiction <= !(st_ff == S_PICK && is_found_now);
            if (st_ff == S_PICK && is_found_now) begin
               prev_ff <= pick_now;
               res_ff.chosen_pattern <= 6'(pick_now);
               res_ff.line_contradictions <= tally_base;
               tally_ff <= tally_base;
            end else begin
               prev_ff <= fb_now;
               res_ff.chosen_pattern <= 6'(fb_now);
               res_ff.line_contradictions <=
                  tally_base == TALLY_MAX ? TALLY_MAX : tally_base + 10'd1;
               tally_ff <= tally_base == TALLY_MAX ? TALLY_MAX : tally_base + 10'd1;
            end
         end
      end
   end

   assign rsp_valid = ov_ff;
   assign rsp_data  = out_ff;
endmodule

[src/wfc_line_collapse_generator_unit.sv]
// Wave-function-collapse line generator, top level. Requests either write one
// pattern-table entry (no response) or generate one cell (one response). A front
// part queues requests in a two-entry queue; the back part walks the pattern table
// held in RAMs: two reads fetch the neighbour and previous-cell masks, one pass over
// the active patterns sums candidate weights and finds the floor fallback, a
// bit-serial remainder reduces the 31-bit random word, and a second pass over the
// active patterns makes the weighted pick, stopping once a pattern is chosen.
// Depends on wlcg_pkg, wlcg_front and wlcg_back.
`timescale 1ns / 1ps
module wfc_line_collapse_generator_unit import wlcg_pkg::*; #(
   parameter int MAX_PATTERNS = 64,
   parameter int WEIGHT_BITS  = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [6:0]  csr_data
);
   logic [6:0] active_ff;
   logic       dir_ff;
   logic       pop, not_empty;
   req_type    q_data;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 7'd1;
         dir_ff    <= 1'b0;
      end else if (csr_write) begin
         if (csr_index == 1'(CSR_ACTIVE)) active_ff <= csr_data;
         if (csr_index == 1'(CSR_DIR))    dir_ff    <= csr_data[0];
      end
   end

   wlcg_front #(.MAX_PATTERNS(MAX_PATTERNS)) u_front (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .pop, .not_empty, .pop_data(q_data)
   );

   wlcg_back #(.MAX_PATTERNS(MAX_PATTERNS), .WEIGHT_BITS(WEIGHT_BITS)) u_back (
      .clock, .reset, .active_patterns(active_ff), .line_direction(dir_ff),
      .q_valid(not_empty), .q_data, .q_pop(pop),
      .rsp_valid, .rsp_stall, .rsp_data
   );
endmodule
